// File: rtl/core/itrd_pkg.sv
// Shared constants, types and helpers for the integer to radix digits block.
package itrd_pkg;

  localparam int VALUE_BITS = 32;
  localparam int IN_VALUE_W = 32;
  localparam int BASE_W     = 8;
  localparam int CHAR_W     = 7;
  localparam int DIGIT_W    = 6;
  localparam int ADDR_W     = $clog2(VALUE_BITS);
  localparam int COUNT_W    = $clog2(VALUE_BITS + 1);

  localparam logic [BASE_W-1:0]  RADIX_MIN     = 8'd2;
  localparam logic [BASE_W-1:0]  RADIX_MAX     = 8'd36;
  localparam logic [CHAR_W-1:0]  CHAR_MINUS    = 7'h2D;
  localparam logic [CHAR_W-1:0]  CHAR_ZERO     = 7'h30;
  localparam logic [CHAR_W-1:0]  CHAR_LETTER_A = 7'h41;
  localparam logic [CHAR_W-1:0]  CHAR_NONE     = 7'h00;
  localparam logic [DIGIT_W-1:0] DIGIT_TEN     = 6'd10;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ERROR,
    ST_DIV_START,
    ST_DIV_WAIT,
    ST_SIGN,
    ST_READ,
    ST_LOAD
  } state_t;

  typedef struct packed {
    logic start;
    logic done;
  } div_ctrl_t;

  function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
    logic [CHAR_W-1:0] c;
    if (d >= DIGIT_TEN) begin
      c = CHAR_LETTER_A + CHAR_W'(d - DIGIT_TEN);
    end else begin
      c = CHAR_ZERO + CHAR_W'(d);
    end
    return c;
  endfunction

endpackage

// File: rtl/core/itrd_if.sv
// Valid/ready channel interfaces for the request and character streams.
interface itrd_in_if;
  import itrd_pkg::*;
  logic                         valid;
  logic                         ready;
  logic signed [IN_VALUE_W-1:0] value;
  logic                         value_is_small;
  logic [BASE_W-1:0]            base;

  modport source (output valid, value, value_is_small, base, input ready);
  modport sink   (input valid, value, value_is_small, base, output ready);
endinterface

interface itrd_out_if;
  import itrd_pkg::*;
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] char_code;
  logic              last;
  logic              bad_argument;

  modport source (output valid, char_code, last, bad_argument, input ready);
  modport sink   (input valid, char_code, last, bad_argument, output ready);
endinterface

// File: rtl/core/itrd_div.sv
// Restoring divider, one quotient bit per cycle, small divisor.
module itrd_div (
  input  logic                                clk,
  input  logic                                rst,
  input  itrd_pkg::div_ctrl_t                 ctrl_in,
  output itrd_pkg::div_ctrl_t                 ctrl_out,
  input  logic [itrd_pkg::VALUE_BITS-1:0]     dividend,
  input  logic [itrd_pkg::DIGIT_W-1:0]        divisor,
  output logic [itrd_pkg::VALUE_BITS-1:0]     quotient,
  output logic [itrd_pkg::DIGIT_W-1:0]        remainder
);
  import itrd_pkg::*;

  logic [VALUE_BITS-1:0] quo;
  logic [DIGIT_W-1:0]    rem;
  logic [COUNT_W-1:0]    count;
  logic                  done;
  logic [DIGIT_W:0]      trial;
  logic                  ge;

  assign trial = {rem, quo[VALUE_BITS-1]};
  assign ge    = trial >= {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      done  <= 1'b0;
    end else if (ctrl_in.start) begin
      count <= COUNT_W'(VALUE_BITS);
      done  <= 1'b0;
    end else begin
      done <= (count == COUNT_W'(1));
      if (count != '0) begin
        count <= count - COUNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl_in.start) begin
      quo <= dividend;
      rem <= '0;
    end else if (count != '0) begin
      quo <= {quo[VALUE_BITS-2:0], ge};
      rem <= ge ? DIGIT_W'(trial - {1'b0, divisor}) : trial[DIGIT_W-1:0];
    end
  end

  always_comb begin
    ctrl_out       = '0;
    ctrl_out.done  = done;
    ctrl_out.start = ctrl_in.start;
  end

  assign quotient  = quo;
  assign remainder = rem;

endmodule

// File: rtl/core/integer_to_radix_digits.sv
// Top level: signed integer to ASCII digits in radix 2..36, most significant first.
// Each digit is computed on the shared bit-serial divider.
// A sign step, then each digit is read back from the digit store through ST_READ and ST_LOAD.
// One item at a time: din.ready is high only while idle.
// Synchronous active-high reset returns the sequencer to idle and empties the output register.
module integer_to_radix_digits (
  input  logic        clk,
  input  logic        rst,
  itrd_in_if.sink     din,
  itrd_out_if.source  dout
);
  import itrd_pkg::*;

  state_t                state, state_next;
  logic [VALUE_BITS-1:0] mag, mag_next;
  logic                  neg, neg_next;
  logic [COUNT_W-1:0]    nd, nd_next;
  logic                  out_valid, out_valid_next;
  logic [CHAR_W-1:0]     out_char, out_char_next;
  logic                  out_last, out_last_next;
  logic                  out_bad, out_bad_next;

  logic [VALUE_BITS-1:0] raw;
  logic                  bad_req;
  logic                  mem_we;
  logic [COUNT_W-1:0]    nd_dec;
  logic [DIGIT_W-1:0]    rd_data;
  logic [DIGIT_W-1:0]    digit_mem [VALUE_BITS];

  div_ctrl_t             div_cmd, div_stat;
  logic [VALUE_BITS-1:0] div_quo;
  logic [DIGIT_W-1:0]    div_rem;
  logic [DIGIT_W-1:0]    din_base_q;

  itrd_div u_div (
    .clk       (clk),
    .rst       (rst),
    .ctrl_in   (div_cmd),
    .ctrl_out  (div_stat),
    .dividend  (mag),
    .divisor   (din_base_q),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  assign raw     = VALUE_BITS'(din.value);
  assign bad_req = (din.base < RADIX_MIN) || (din.base > RADIX_MAX) || !din.value_is_small;
  assign nd_dec  = nd - COUNT_W'(1);

  always_ff @(posedge clk) begin
    if (state == ST_IDLE) begin
      din_base_q <= din.base[DIGIT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      digit_mem[nd[ADDR_W-1:0]] <= div_rem;
    end
    rd_data <= digit_mem[nd_dec[ADDR_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    mag      <= mag_next;
    neg      <= neg_next;
    nd       <= nd_next;
    out_char <= out_char_next;
    out_last <= out_last_next;
    out_bad  <= out_bad_next;
  end

  always_comb begin
    state_next     = state;
    mag_next       = mag;
    neg_next       = neg;
    nd_next        = nd;
    out_valid_next = out_valid;
    out_char_next  = out_char;
    out_last_next  = out_last;
    out_bad_next   = out_bad;
    mem_we         = 1'b0;
    div_cmd        = '0;
    if (dout.ready) begin
      out_valid_next = 1'b0;
    end
    case (state)
      ST_IDLE: begin
        if (din.valid) begin
          if (bad_req) begin
            state_next = ST_ERROR;
          end else begin
            neg_next   = raw[VALUE_BITS-1];
            mag_next   = raw[VALUE_BITS-1] ? (~raw + VALUE_BITS'(1)) : raw;
            nd_next    = '0;
            state_next = ST_DIV_START;
          end
        end
      end
      ST_ERROR: begin
        if (!out_valid) begin
          out_valid_next = 1'b1;
          out_char_next  = CHAR_NONE;
          out_last_next  = 1'b1;
          out_bad_next   = 1'b1;
          state_next     = ST_IDLE;
        end
      end
      ST_DIV_START: begin
        div_cmd.start = 1'b1;
        state_next    = ST_DIV_WAIT;
      end
      ST_DIV_WAIT: begin
        if (div_stat.done) begin
          mem_we     = 1'b1;
          nd_next    = nd + COUNT_W'(1);
          mag_next   = div_quo;
          state_next = (div_quo == '0) ? ST_SIGN : ST_DIV_START;
        end
      end
      ST_SIGN: begin
        if (!neg) begin
          state_next = ST_READ;
        end else if (!out_valid) begin
          out_valid_next = 1'b1;
          out_char_next  = CHAR_MINUS;
          out_last_next  = 1'b0;
          out_bad_next   = 1'b0;
          state_next     = ST_READ;
        end
      end
      ST_READ: begin
        state_next = ST_LOAD;
      end
      ST_LOAD: begin
        if (!out_valid) begin
          out_valid_next = 1'b1;
          out_char_next  = digit_char(rd_data);
          out_last_next  = (nd == COUNT_W'(1));
          out_bad_next   = 1'b0;
          nd_next        = nd_dec;
          state_next     = (nd == COUNT_W'(1)) ? ST_IDLE : ST_READ;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  assign din.ready         = (state == ST_IDLE);
  assign dout.valid        = out_valid;
  assign dout.char_code    = out_char;
  assign dout.last         = out_last;
  assign dout.bad_argument = out_bad;

endmodule

// File: rtl/core/itrd_checker.sv
// Port-level checks for integer_to_radix_digits, attached by bind.
module itrd_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [itrd_pkg::CHAR_W-1:0] char_code,
  input logic                        last,
  input logic                        bad_argument
);
  import itrd_pkg::*;

  // error transaction is a lone zero character
  a_bad_is_final: assert property (@(posedge clk) disable iff (rst)
    out_valid && bad_argument |-> last && (char_code == CHAR_NONE))
    else $error("error result not final or not zero");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("new request taken while converting");

  a_busy_mid_string: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !last |=> !in_ready)
    else $error("request taken before string complete");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(char_code) && $stable(last))
    else $error("stalled output changed");

endmodule

bind integer_to_radix_digits itrd_checker u_itrd_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (din.valid),
  .in_ready     (din.ready),
  .out_valid    (dout.valid),
  .out_ready    (dout.ready),
  .char_code    (dout.char_code),
  .last         (dout.last),
  .bad_argument (dout.bad_argument)
);
